FILE: design/wlrp_pkg.sv
// Shared types and constants of the write log replay parser.
package wlrp_pkg;

    // Record layout.
    localparam int unsigned FIXED_DATA_BYTES = 4;
    localparam int unsigned VAR_HEADER_BYTES = 4;
    localparam logic [7:0]  VAR_MARKER       = 8'hFF;
    localparam logic [7:0]  ERASED_BYTE      = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOG_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_RECS = 2'd1;
    localparam logic [1:0] CFG_TARGET_SIZE   = 2'd2;

    localparam logic [15:0] LOG_LENGTH_RESET    = 16'd1;
    localparam logic [15:0] EXPECTED_RECS_RESET = 16'd0;
    localparam logic [16:0] TARGET_SIZE_RESET   = 17'd0;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_FIX_LO,
        PH_VAR_LEN,
        PH_VAR_HI,
        PH_VAR_LO,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [15:0] log_length;
        logic [15:0] expected_recs;
        logic [16:0] target_size;
    } cfg_t;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_offset;
        logic [7:0]  write_byte;
        logic        done_res;
        logic        success;
        logic [15:0] used_bytes;
    } result_t;

endpackage

FILE: design/write_log_replay_parser_top.sv
// Top level of the write log replay parser: input register, parse step, result register.
// Accepts one log byte per clock while results are taken, returning one result word per byte:
// the input register holds the byte, the combinational parse step computes its word, and the
// result register loads that word once it has room, so bytes stream back to back; when the output
// stalls, the input stalls once both registers hold a word. Configuration must be written by
// the user through the plain write port only while no replay byte is in flight; the block
// itself does not enforce this. No clearing pass is needed after reset.
module write_log_replay_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    // Log input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] log_byte
    input  logic        s_tuser,   // [0] restart
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] write_offset, [23:16] write_byte, [39:24] used_bytes
    output logic [2:0]  m_tuser,   // [0] write_valid, [1] done_res, [2] success
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    wlrp_pkg::cfg_t    cfg;
    wlrp_pkg::result_t step_res;
    wlrp_pkg::result_t out_res_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;
    logic       out_valid_reg;
    logic       out_ready;
    logic       fire;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg    <= s_tdata;
            in_restart_reg <= s_tuser;
        end
        if (fire)
        begin
            out_res_reg <= step_res;
        end
    end

    wlrp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wlrp_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .log_byte (in_byte_reg),
        .restart  (in_restart_reg),
        .cfg      (cfg),
        .res      (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.used_bytes, out_res_reg.write_byte, out_res_reg.write_offset};
    assign m_tuser  = {out_res_reg.success, out_res_reg.done_res, out_res_reg.write_valid};

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted word not held in the input register");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("parsed word not held in the result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !fire)
        else $error("parse step fired while the result register was stalled");

endmodule

FILE: design/wlrp_cfg.sv
// Configuration registers of the write log replay parser.
module wlrp_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [16:0]       cfg_data,
    output wlrp_pkg::cfg_t    cfg
);

    logic [15:0] log_length_reg;
    logic [15:0] expected_recs_reg;
    logic [16:0] target_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_length_reg    <= wlrp_pkg::LOG_LENGTH_RESET;
            expected_recs_reg <= wlrp_pkg::EXPECTED_RECS_RESET;
            target_size_reg   <= wlrp_pkg::TARGET_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wlrp_pkg::CFG_LOG_LENGTH:    log_length_reg    <= cfg_data[15:0];
                wlrp_pkg::CFG_EXPECTED_RECS: expected_recs_reg <= cfg_data[15:0];
                wlrp_pkg::CFG_TARGET_SIZE:   target_size_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.log_length    = log_length_reg;
    assign cfg.expected_recs = expected_recs_reg;
    assign cfg.target_size   = target_size_reg;

endmodule

FILE: design/wlrp_step.sv
// Replay state and the combinational parse step for one log byte.
module wlrp_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           log_byte,
    input  logic                 restart,
    input  wlrp_pkg::cfg_t       cfg,
    output wlrp_pkg::result_t    res
);

    localparam logic [16:0] FIX_MIN_REMAIN = 17'(wlrp_pkg::FIXED_DATA_BYTES + 2);
    localparam logic [16:0] FIX_LEN        = 17'(wlrp_pkg::FIXED_DATA_BYTES);
    localparam logic [7:0]  FIX_COUNT      = 8'(wlrp_pkg::FIXED_DATA_BYTES);
    localparam logic [17:0] VAR_HDR_LEN    = 18'(wlrp_pkg::VAR_HEADER_BYTES);

    wlrp_pkg::phase_t phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] rec_reg, rec_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [15:0] wp_reg, wp_next;
    logic [7:0]  dr_reg, dr_next;
    logic        fin_reg, fin_next;
    logic [15:0] end_reg, end_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wlrp_pkg::PH_FIRST;
            pos_reg   <= '0;
            rec_reg   <= '0;
            hdr_reg   <= '0;
            wp_reg    <= '0;
            dr_reg    <= '0;
            fin_reg   <= 1'b0;
            end_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rec_reg   <= rec_next;
            hdr_reg   <= hdr_next;
            wp_reg    <= wp_next;
            dr_reg    <= dr_next;
            fin_reg   <= fin_next;
            end_reg   <= end_next;
        end
    end

    always_comb
    begin
        wlrp_pkg::phase_t phase;
        logic [15:0] pos;
        logic [15:0] rec;
        logic [15:0] hdr;
        logic [15:0] wp;
        logic [7:0]  dr;
        logic        fin;
        logic [15:0] rend;
        logic [15:0] remaining;
        logic [15:0] off;
        logic [7:0]  len;
        logic [15:0] rec_inc;
        logic [7:0]  dr_dec;

        // A restart clears the replay before its own byte is parsed.
        phase = restart ? wlrp_pkg::PH_FIRST : phase_reg;
        pos   = restart ? 16'd0 : pos_reg;
        rec   = restart ? 16'd0 : rec_reg;
        hdr   = restart ? 16'd0 : hdr_reg;
        wp    = restart ? 16'd0 : wp_reg;
        dr    = restart ? 8'd0 : dr_reg;
        fin   = restart ? 1'b0 : fin_reg;
        rend  = restart ? 16'd0 : end_reg;

        phase_next = phase;
        pos_next   = pos;
        rec_next   = rec;
        hdr_next   = hdr;
        wp_next    = wp;
        dr_next    = dr;
        fin_next   = fin;
        end_next   = rend;
        res        = '0;
        remaining  = cfg.log_length - pos;
        off        = {hdr[7:0], log_byte};
        len        = hdr[15:8];
        rec_inc    = rec + 16'd1;
        dr_dec     = dr - 8'd1;

        if (!fin)
        begin
            if (pos >= cfg.log_length)
            begin
                res.done_res = 1'b1;
                fin_next     = 1'b1;
            end
            else
            begin
                pos_next = pos + 16'd1;
                unique case (phase)
                    wlrp_pkg::PH_FIRST:
                    begin
                        if (rec >= cfg.expected_recs)
                        begin
                            // Past the last record only erased bytes may follow.
                            if (log_byte != wlrp_pkg::ERASED_BYTE)
                            begin
                                res.done_res = 1'b1;
                                fin_next     = 1'b1;
                            end
                            else if (remaining == 16'd1)
                            begin
                                res.done_res   = 1'b1;
                                res.success    = 1'b1;
                                res.used_bytes = rend;
                                fin_next       = 1'b1;
                            end
                        end
                        else if (log_byte != wlrp_pkg::VAR_MARKER)
                        begin
                            if ({1'b0, remaining} < FIX_MIN_REMAIN)
                            begin
                                res.done_res = 1'b1;
                                fin_next     = 1'b1;
                            end
                            else
                            begin
                                hdr_next   = {8'd0, log_byte};
                                phase_next = wlrp_pkg::PH_FIX_LO;
                            end
                        end
                        else
                        begin
                            if (18'(remaining) < VAR_HDR_LEN)
                            begin
                                res.done_res = 1'b1;
                                fin_next     = 1'b1;
                            end
                            else
                            begin
                                hdr_next   = {8'd0, log_byte};
                                phase_next = wlrp_pkg::PH_VAR_LEN;
                            end
                        end
                    end
                    wlrp_pkg::PH_FIX_LO:
                    begin
                        if ({1'b0, off} + FIX_LEN > cfg.target_size)
                        begin
                            res.done_res = 1'b1;
                            fin_next     = 1'b1;
                        end
                        else
                        begin
                            wp_next    = off;
                            dr_next    = FIX_COUNT;
                            phase_next = wlrp_pkg::PH_DATA;
                        end
                    end
                    wlrp_pkg::PH_VAR_LEN,
                    wlrp_pkg::PH_VAR_HI:
                    begin
                        // Keeps the length and the offset high byte; the marker is known.
                        hdr_next   = {hdr[7:0], log_byte};
                        phase_next = (phase == wlrp_pkg::PH_VAR_LEN) ?
                                     wlrp_pkg::PH_VAR_HI : wlrp_pkg::PH_VAR_LO;
                    end
                    wlrp_pkg::PH_VAR_LO:
                    begin
                        hdr_next = {hdr[7:0], log_byte};
                        if ((wlrp_pkg::VAR_MARKER == 8'hFF && len == 8'hFF &&
                             hdr[7:0] == 8'hFF && log_byte == 8'hFF) ||
                            len == 8'd0 ||
                            18'(remaining) + 18'd3 < VAR_HDR_LEN + 18'(len) ||
                            {1'b0, off} + 17'(len) > cfg.target_size)
                        begin
                            res.done_res = 1'b1;
                            fin_next     = 1'b1;
                        end
                        else
                        begin
                            wp_next    = off;
                            dr_next    = len;
                            phase_next = wlrp_pkg::PH_DATA;
                        end
                    end
                    wlrp_pkg::PH_DATA:
                    begin
                        res.write_valid  = 1'b1;
                        res.write_offset = wp;
                        res.write_byte   = log_byte;
                        wp_next          = wp + 16'd1;
                        dr_next          = dr_dec;
                        if (dr_dec == 8'd0)
                        begin
                            rec_next   = rec_inc;
                            end_next   = pos + 16'd1;
                            phase_next = wlrp_pkg::PH_FIRST;
                            if ({1'b0, pos} + 17'd1 == {1'b0, cfg.log_length})
                            begin
                                res.done_res = 1'b1;
                                fin_next     = 1'b1;
                                if (rec_inc >= cfg.expected_recs)
                                begin
                                    res.success    = 1'b1;
                                    res.used_bytes = pos + 16'd1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        res.done_res = 1'b1;
                        fin_next     = 1'b1;
                    end
                endcase
            end
        end
    end

    a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_res |=> fin_reg)
        else $error("replay outcome given but parser not finished");

    a_finished_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fin_reg && !restart |-> !res.write_valid && !res.done_res)
        else $error("finished parser produced a write or an outcome");

    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.write_valid |=> wp_reg == 16'($past(res.write_offset) + 16'd1))
        else $error("write pointer did not advance after a data byte");

    a_success_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.success |-> res.done_res && phase_next == wlrp_pkg::PH_FIRST)
        else $error("success reported outside a record boundary");

endmodule

FILE: tb/tb_write_log_replay_parser_top.sv
// Self-checking testbench: streams flash write logs into the replay parser and checks every result word.
module tb_write_log_replay_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_BYTES = 1350;
    localparam int unsigned CHOKE_CYCLES = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } feed_item_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = wlrp_pkg::CFG_LOG_LENGTH;
    logic [16:0] cfg_data  = '0;

    // Log bytes waiting to be offered, and result words predicted for accepted bytes.
    feed_item_t           log_feed[$];
    wlrp_pkg::result_t    want_results[$];
    feed_item_t           next_byte;

    // Mirror of the configuration and of the replay state.
    int unsigned          cfg_len;
    int unsigned          cfg_count;
    int unsigned          cfg_size;
    logic [15:0]          rp_pos;
    logic [15:0]          rp_recs;
    logic [15:0]          rp_wptr;
    logic [7:0]           rp_left;
    wlrp_pkg::phase_t     rp_phase;
    int unsigned          rp_hdr;
    int unsigned          rp_end;
    bit                   rp_done;

    bit          calm        = 1'b0;
    bit          choke_armed = 1'b0;
    bit          choke_done  = 1'b0;
    int unsigned choke_left  = 0;
    int unsigned stall_left  = 0;
    int unsigned hold_cycles = 0;
    int unsigned cycles      = 0;
    int unsigned errors      = 0;
    int unsigned bytes_fed   = 0;
    int unsigned random_bytes = 0;
    int unsigned replays     = 0;
    int unsigned settings    = 0;
    int unsigned writes_seen = 0;
    int unsigned good_logs   = 0;
    int unsigned bad_logs    = 0;
    wlrp_pkg::result_t seen;
    wlrp_pkg::result_t want;

    write_log_replay_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void clear_replay();
        rp_pos   = '0;
        rp_recs  = '0;
        rp_phase = wlrp_pkg::PH_FIRST;
        rp_hdr   = 0;
        rp_wptr  = '0;
        rp_left  = '0;
        rp_done  = 1'b0;
        rp_end   = 0;
    endfunction

    function automatic void settle(inout wlrp_pkg::result_t r, input bit ok,
                                   input int unsigned used);
        rp_done     = 1'b1;
        r.done_res  = 1'b1;
        r.success   = ok;
        r.used_bytes = ok ? used[15:0] : 16'd0;
    endfunction

    // Advances the replay by one log byte and returns the result word it produces.
    function automatic wlrp_pkg::result_t replay_step(input logic [7:0] b, input logic restart);
        wlrp_pkg::result_t r;
        int unsigned pos;
        int unsigned remaining;
        int unsigned off;
        int unsigned len;
        r = '0;
        if (restart)
            clear_replay();
        if (rp_done)
            return r;
        pos = rp_pos;
        if (pos >= cfg_len)
        begin
            settle(r, 1'b0, 0);
            return r;
        end
        remaining = cfg_len - pos;
        rp_pos = rp_pos + 16'd1;
        case (rp_phase)
            wlrp_pkg::PH_FIRST:
            begin
                if (rp_recs >= cfg_count)
                begin
                    if (b != wlrp_pkg::ERASED_BYTE)
                        settle(r, 1'b0, 0);
                    else if (remaining == 1)
                        settle(r, 1'b1, rp_end);
                end
                else if (b != wlrp_pkg::VAR_MARKER)
                begin
                    if (remaining < wlrp_pkg::FIXED_DATA_BYTES + 2)
                        settle(r, 1'b0, 0);
                    else
                    begin
                        rp_hdr   = b;
                        rp_phase = wlrp_pkg::PH_FIX_LO;
                    end
                end
                else
                begin
                    if (remaining < wlrp_pkg::VAR_HEADER_BYTES)
                        settle(r, 1'b0, 0);
                    else
                    begin
                        rp_hdr   = b;
                        rp_phase = wlrp_pkg::PH_VAR_LEN;
                    end
                end
            end
            wlrp_pkg::PH_FIX_LO:
            begin
                off = ((rp_hdr & 32'hFF) << 8) | b;
                if (off + wlrp_pkg::FIXED_DATA_BYTES > cfg_size)
                    settle(r, 1'b0, 0);
                else
                begin
                    rp_wptr  = off[15:0];
                    rp_left  = 8'(wlrp_pkg::FIXED_DATA_BYTES);
                    rp_phase = wlrp_pkg::PH_DATA;
                end
            end
            wlrp_pkg::PH_VAR_LEN:
            begin
                rp_hdr   = (rp_hdr << 8) | b;
                rp_phase = wlrp_pkg::PH_VAR_HI;
            end
            wlrp_pkg::PH_VAR_HI:
            begin
                rp_hdr   = (rp_hdr << 8) | b;
                rp_phase = wlrp_pkg::PH_VAR_LO;
            end
            wlrp_pkg::PH_VAR_LO:
            begin
                rp_hdr = (rp_hdr << 8) | b;
                len = (rp_hdr >> 16) & 32'hFF;
                off = rp_hdr & 32'hFFFF;
                // The record started three bytes back, so remaining + 3 bytes are left for it.
                if (rp_hdr == 32'hFFFF_FFFF || len == 0 ||
                    remaining + 3 < wlrp_pkg::VAR_HEADER_BYTES + len || off + len > cfg_size)
                    settle(r, 1'b0, 0);
                else
                begin
                    rp_wptr  = off[15:0];
                    rp_left  = len[7:0];
                    rp_phase = wlrp_pkg::PH_DATA;
                end
            end
            wlrp_pkg::PH_DATA:
            begin
                r.write_valid  = 1'b1;
                r.write_offset = rp_wptr;
                r.write_byte   = b;
                rp_wptr = rp_wptr + 16'd1;
                rp_left = rp_left - 8'd1;
                if (rp_left == 8'd0)
                begin
                    rp_recs  = rp_recs + 16'd1;
                    rp_end   = pos + 1;
                    rp_phase = wlrp_pkg::PH_FIRST;
                    if (pos + 1 == cfg_len)
                        settle(r, rp_recs >= cfg_count, rp_end);
                end
            end
            default:
                settle(r, 1'b0, 0);
        endcase
        return r;
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return 0;
        else if (sel < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[16:0];
        case (idx)
            wlrp_pkg::CFG_LOG_LENGTH:    cfg_len   = val & 32'hFFFF;
            wlrp_pkg::CFG_EXPECTED_RECS: cfg_count = val & 32'hFFFF;
            wlrp_pkg::CFG_TARGET_SIZE:   cfg_size  = val & 32'h1FFFF;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input int unsigned len, input int unsigned count,
                                input int unsigned size);
        write_reg(wlrp_pkg::CFG_LOG_LENGTH, len);
        write_reg(wlrp_pkg::CFG_EXPECTED_RECS, count);
        write_reg(wlrp_pkg::CFG_TARGET_SIZE, size);
        settings++;
    endtask

    // Checked between clock edges so that the sender's updates are already visible.
    task automatic wait_idle();
        while (!(log_feed.size() == 0 && !s_tvalid && want_results.size() == 0))
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Queues one replay: the first byte carries restart, the rest do not.
    task automatic push_replay(input logic [7:0] img[$]);
        foreach (img[k])
            log_feed.push_back(feed_item_t'{data: img[k], restart: (k == 0)});
        replays++;
    endtask

    // Builds a log of nrec records followed by erased space, then maybe damages it.
    task automatic gen_replay(input int unsigned nrec, input int unsigned cap,
                              input int unsigned maxlen);
        logic [7:0]  img[$];
        int unsigned left;
        int unsigned len;
        int unsigned off;
        int unsigned lim;
        int unsigned mode;
        int unsigned cut;
        bit          use_var;
        mode = $urandom_range(0, 99);
        // A record short of the configured count.
        if (mode >= 93 && nrec > 0)
            nrec--;
        left = (cfg_len < cap) ? cfg_len : cap;
        for (int i = 0; i < nrec; i++)
        begin
            use_var = cfg_size < wlrp_pkg::FIXED_DATA_BYTES ||
                      left < wlrp_pkg::FIXED_DATA_BYTES + 2 ||
                      $urandom_range(0, 1) == 1;
            if (use_var)
            begin
                if (cfg_size == 0 || left < wlrp_pkg::VAR_HEADER_BYTES + 1)
                    break;
                lim = left - wlrp_pkg::VAR_HEADER_BYTES;
                if (lim > cfg_size)
                    lim = cfg_size;
                if (lim > maxlen)
                    lim = maxlen;
                len = $urandom_range(1, lim);
                // Sometimes the last record ends exactly on the last byte of the image.
                if (i == nrec - 1 && left - wlrp_pkg::VAR_HEADER_BYTES <= cfg_size &&
                    left - wlrp_pkg::VAR_HEADER_BYTES <= 255 && $urandom_range(0, 1) == 1)
                    len = left - wlrp_pkg::VAR_HEADER_BYTES;
                off = $urandom_range(0, cfg_size - len);
                img.push_back(wlrp_pkg::VAR_MARKER);
                img.push_back(len[7:0]);
                img.push_back(off[15:8]);
                img.push_back(off[7:0]);
                left -= wlrp_pkg::VAR_HEADER_BYTES + len;
            end
            else
            begin
                lim = cfg_size - wlrp_pkg::FIXED_DATA_BYTES;
                if (lim > 32'hFEFF)
                    lim = 32'hFEFF;
                off = $urandom_range(0, lim);
                img.push_back(off[15:8]);
                img.push_back(off[7:0]);
                len = wlrp_pkg::FIXED_DATA_BYTES;
                left -= 2 + len;
            end
            repeat (len) img.push_back(8'($urandom));
        end
        repeat (left) img.push_back(wlrp_pkg::ERASED_BYTE);
        if (mode >= 60 && mode < 75)
            img[$urandom_range(0, img.size() - 1)] = 8'($urandom);
        else if (mode >= 75 && mode < 85 && img.size() > 1)
        begin
            cut = $urandom_range(1, img.size() - 1);
            img = img[0:cut-1];
        end
        else if (mode >= 85 && mode < 93)
            foreach (img[k]) img[k] = 8'($urandom);
        random_bytes += img.size();
        push_replay(img);
        // Stray bytes after the end are ignored once the outcome is out.
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                log_feed.push_back(feed_item_t'{data: 8'($urandom), restart: 1'b0});
    endtask

    // Sender: offers queued log bytes, predicting each word as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                want_results.push_back(replay_step(s_tdata, s_tuser));
                bytes_fed++;
                hold_cycles = calm ? 0 : pick_pause();
            end
            if (!s_tvalid || s_tready)
            begin
                if (hold_cycles > 0)
                begin
                    hold_cycles--;
                    s_tvalid <= 1'b0;
                end
                else if (log_feed.size() > 0)
                begin
                    next_byte = log_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.data;
                    s_tuser  <= next_byte.restart;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word against the oldest prediction and paces m_tready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.write_valid  = m_tuser[0];
                seen.done_res     = m_tuser[1];
                seen.success      = m_tuser[2];
                seen.write_offset = m_tdata[15:0];
                seen.write_byte   = m_tdata[23:16];
                seen.used_bytes   = m_tdata[39:24];
                if (want_results.size() == 0)
                begin
                    if (errors < 25)
                        $display("%0t: result word with nothing expected: %h", $time, seen);
                    errors++;
                end
                else
                begin
                    want = want_results.pop_front();
                    if (seen !== want)
                    begin
                        if (errors < 25)
                        begin
                            $display("%0t: mismatch expected wv=%0b off=%h byte=%h done=%0b %s",
                                     $time, want.write_valid, want.write_offset,
                                     want.write_byte, want.done_res, "");
                            $display("%0t:          expected ok=%0b used=%0d",
                                     $time, want.success, want.used_bytes);
                            $display("%0t:          actual wv=%0b off=%h byte=%h done=%0b",
                                     $time, seen.write_valid, seen.write_offset,
                                     seen.write_byte, seen.done_res);
                            $display("%0t:          actual ok=%0b used=%0d",
                                     $time, seen.success, seen.used_bytes);
                        end
                        errors++;
                    end
                end
                if (seen.write_valid)
                    writes_seen++;
                if (seen.done_res && seen.success)
                    good_logs++;
                else if (seen.done_res)
                    bad_logs++;
            end
            // One long hold-off while plenty of bytes are still queued, to back up the input.
            if (choke_armed && !choke_done && log_feed.size() >= 16)
            begin
                choke_done = 1'b1;
                choke_left = CHOKE_CYCLES;
            end
            if (choke_left > 0)
            begin
                choke_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (calm)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                stall_left = pick_pause();
                m_tready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_write_log_replay_parser_top: errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned sel;
        int unsigned len;
        int unsigned count;
        int unsigned size;
        int unsigned cap;
        int unsigned maxlen;
        int unsigned reps;

        cfg_len   = wlrp_pkg::LOG_LENGTH_RESET;
        cfg_count = wlrp_pkg::EXPECTED_RECS_RESET;
        cfg_size  = wlrp_pkg::TARGET_SIZE_RESET;
        clear_replay();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: a fixed and a variable record filling the log exactly, then the
        // header failures, a byte after the outcome, and a log shortened mid-replay.
        program_regs(12, 2, 16);
        push_replay('{8'h00, 8'h0C, 8'h00, 8'hFF, 8'h5A, 8'hA5,
                      8'hFF, 8'h02, 8'h00, 8'h00, 8'h80, 8'h7F});
        push_replay('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
        push_replay('{8'hFF, 8'h00, 8'h00, 8'h00});
        push_replay('{8'h00, 8'h0D});
        log_feed.push_back(feed_item_t'{data: 8'h11, restart: 1'b0});
        push_replay('{8'h00, 8'h00, 8'h11});
        wait_idle();
        write_reg(wlrp_pkg::CFG_LOG_LENGTH, 1);
        log_feed.push_back(feed_item_t'{data: 8'h22, restart: 1'b0});
        wait_idle();

        choke_armed <= 1'b1;
        while (random_bytes < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
            begin
                len    = 65535;
                count  = ($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(1, 3);
                size   = 65536;
                cap    = 60;
                maxlen = 8;
                reps   = 3;
            end
            else if (sel < 9)
            begin
                len    = 1;
                count  = 0;
                size   = ($urandom_range(0, 1) == 1) ? 0 : 65536;
                cap    = 1;
                maxlen = 1;
                reps   = 6;
            end
            else if (sel < 12)
            begin
                len    = $urandom_range(260, 300);
                count  = 1;
                size   = 65536;
                cap    = len;
                maxlen = 255;
                reps   = 1;
            end
            else
            begin
                count = $urandom_range(0, 4);
                case ($urandom_range(0, 5))
                    0:       size = 0;
                    1:       size = $urandom_range(1, 12);
                    2, 3:    size = $urandom_range(4, 400);
                    4:       size = 65535;
                    default: size = 65536;
                endcase
                len    = count * 10 + $urandom_range(1, 10);
                cap    = len;
                maxlen = 8;
                reps   = $urandom_range(2, 5);
            end
            program_regs(len, count, size);
            calm <= ($urandom_range(0, 3) == 0);
            repeat (reps) gen_replay(count, cap, maxlen);
            wait_idle();
        end

        wait_idle();
        $display("Fed %0d log bytes in %0d replays across %0d register settings.",
                 bytes_fed, replays, settings);
        $display("Saw %0d image writes, %0d good and %0d corrupt log outcomes.",
                 writes_seen, good_logs, bad_logs);
        if (errors == 0)
            $display("tb_write_log_replay_parser_top: clean");
        else
            $display("tb_write_log_replay_parser_top: errors");
        $finish;
    end

endmodule
